>>> rtl/tlru_pkg.sv
package tlru_pkg;

  localparam int SETS  = 1024;
  localparam int WAYS  = 16;
  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = 4;
  localparam int POS_W = 4;
  localparam int ROW_W = WAYS * POS_W;

  typedef logic [ROW_W-1:0] row_t;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_TOUCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim;
    row_t             new_row;
    logic             touch_ok;
  } upd_t;

  function automatic row_t ident_row();
    row_t r;
    r = '0;
    for (int w = 0; w < WAYS; w++) begin
      r[w*POS_W +: POS_W] = POS_W'(w);
    end
    return r;
  endfunction

endpackage

>>> rtl/tlru_row_update.sv
module tlru_row_update import tlru_pkg::*; (
  input  row_t             row,
  input  logic [WAY_W-1:0] way,
  output upd_t             upd
);

  logic [POS_W-1:0] cur;
  logic             found;

  assign cur = row[way*POS_W +: POS_W];

  always_comb begin
    upd.victim   = '0;
    upd.new_row  = row;
    upd.touch_ok = ({1'b0, way} < (WAY_W+1)'(WAYS));
    found        = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && row[w*POS_W +: POS_W] == POS_W'(WAYS - 1)) begin
        upd.victim = WAY_W'(w);
        found      = 1'b1;
      end
      if (row[w*POS_W +: POS_W] < cur) begin
        upd.new_row[w*POS_W +: POS_W] = row[w*POS_W +: POS_W] + POS_W'(1);
      end
      if (WAY_W'(w) == way) begin
        upd.new_row[w*POS_W +: POS_W] = '0;
      end
    end
  end

endmodule

>>> rtl/true_lru_replacement.sv
// True-LRU replacement state for a 1024-set, 16-way cache, one 64-bit row of
// 4-bit stack positions per set in a single-port synchronous RAM. A query
// (operation 0) returns the way at the bottom of the stack for its set; a
// touch (operation 1) moves the named way to the top and returns nothing.
// Each item is handled in two steps: one RAM read, then the compare/update and
// the write-back of the row; no new item is taken until the last one is done.
// After reset the RAM is loaded with identity order, one row a cycle, for all
// 1024 sets; in_ready stays low until that sweep is done. A finished
// victim waits in an output register and does not stop the next item from
// being taken; only a second query behind an untaken result stalls.
module true_lru_replacement import tlru_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             operation,
  input  logic [SET_W-1:0] set_index,
  input  logic [WAY_W-1:0] way,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WAY_W-1:0] victim_way
);

  state_t           state, state_next;
  logic [SET_W-1:0] clr_addr;
  op_t              item_op;
  logic [SET_W-1:0] item_set;
  logic [WAY_W-1:0] item_way;

  row_t             mem [SETS];
  row_t             rd_row;
  logic             mem_we;
  logic [SET_W-1:0] wr_addr;
  row_t             wr_row;
  logic             in_acc;
  logic             load_out;
  upd_t             upd;

  tlru_row_update u_upd (
    .row (rd_row),
    .way (item_way),
    .upd (upd)
  );

  assign in_acc = in_valid && in_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    wr_addr    = item_set;
    wr_row     = upd.new_row;
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
        wr_row  = ident_row();
        if (clr_addr == SET_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (item_op == OP_TOUCH) begin
          mem_we     = upd.touch_ok;
          state_next = ST_IDLE;
        end else if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + SET_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_op  <= op_t'(operation);
      item_set <= set_index;
      item_way <= way;
    end
    if (load_out) begin
      victim_way <= upd.victim;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_row;
    end
    if (in_acc) begin
      rd_row <= mem[set_index];
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("item accepted while another is in work");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || (state == ST_EXEC && item_op == OP_TOUCH)))
    else $error("row written outside clear or touch");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EXEC && item_op == OP_QUERY))
    else $error("result produced without a query");

  a_exec_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_EXEC)
    else $error("accepted item not executed");

endmodule

>>> sim/tb_true_lru_replacement.sv
module tb_true_lru_replacement;
  import tlru_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1630;
  localparam int LIMIT    = 200000;

  typedef struct {
    op_t              op;
    logic [SET_W-1:0] sidx;
    logic [WAY_W-1:0] w;
    bit               typed;
    logic [WAY_W-1:0] victim;
  } dir_row_t;

  typedef struct {
    logic [SET_W-1:0] sidx;
    logic [WAY_W-1:0] victim;
  } victim_exp_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             operation = 1'b0;
  logic [SET_W-1:0] set_index = '0;
  logic [WAY_W-1:0] way = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [WAY_W-1:0] victim_way;

  logic [POS_W-1:0] lru_stack [SETS][WAYS];
  victim_exp_t      pending_victims [$];
  dir_row_t         dir_rows [$];
  logic [SET_W-1:0] hot_sets [6];

  int  n_sent = 0;
  int  n_touches = 0;
  int  n_checked = 0;
  int  errors = 0;
  int  cycle_cnt = 0;
  logic calm;

  assign calm = (n_sent >= 900) && (n_sent < 1200);

  true_lru_replacement DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .set_index  (set_index),
    .way        (way),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .victim_way (victim_way)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [WAY_W-1:0] lru_victim(logic [SET_W-1:0] s);
    for (int i = 0; i < WAYS; i++) begin
      if (lru_stack[s][i] == POS_W'(WAYS - 1)) return WAY_W'(i);
    end
    return '0;
  endfunction

  function automatic void lru_touch(logic [SET_W-1:0] s, logic [WAY_W-1:0] w);
    logic [POS_W-1:0] cur;
    if (int'(w) < WAYS) begin
      cur = lru_stack[s][w];
      for (int i = 0; i < WAYS; i++) begin
        if (lru_stack[s][i] < cur) lru_stack[s][i] = lru_stack[s][i] + 1'b1;
      end
      lru_stack[s][w] = '0;
    end
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic offer(input op_t op, input logic [SET_W-1:0] s,
                       input logic [WAY_W-1:0] w, input bit typed,
                       input logic [WAY_W-1:0] typed_victim);
    bit taken;
    if (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    set_index <= s;
    way       <= w;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    n_sent++;
    if (op == OP_QUERY) begin
      pending_victims.push_back('{s, typed ? typed_victim : lru_victim(s)});
    end else begin
      n_touches++;
      lru_touch(s, w);
    end
  endtask

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d lookups outstanding", cycle_cnt,
             pending_victims.size());
    $display("true_lru_replacement regression: fail");
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_sent >= 400) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin
    victim_exp_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_victims.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, victim_way %0d", $time, victim_way);
        end else begin
          want = pending_victims.pop_front();
          n_checked++;
          if (victim_way !== want.victim) begin
            errors++;
            $display("%0t: victim_way mismatch in set %0d: expected %0d, actual %0d",
                     $time, want.sidx, want.victim, victim_way);
          end
        end
      end
    end
  end

  initial begin
    op_t              op;
    logic [SET_W-1:0] s;
    logic [WAY_W-1:0] w;
    dir_row_t         row;

    for (int i = 0; i < SETS; i++)
      for (int j = 0; j < WAYS; j++)
        lru_stack[i][j] = POS_W'(j);

    dir_rows.push_back('{OP_QUERY, 10'd0,    4'd0,  1'b1, 4'd15});
    dir_rows.push_back('{OP_QUERY, 10'd1023, 4'd15, 1'b1, 4'd15});
    dir_rows.push_back('{OP_QUERY, 10'd512,  4'd9,  1'b1, 4'd15});
    dir_rows.push_back('{OP_TOUCH, 10'd0,    4'd15, 1'b0, 4'd0});
    dir_rows.push_back('{OP_QUERY, 10'd0,    4'd0,  1'b1, 4'd14});
    dir_rows.push_back('{OP_TOUCH, 10'd0,    4'd14, 1'b0, 4'd0});
    dir_rows.push_back('{OP_QUERY, 10'd0,    4'd0,  1'b1, 4'd13});
    dir_rows.push_back('{OP_TOUCH, 10'd1023, 4'd0,  1'b0, 4'd0});
    dir_rows.push_back('{OP_QUERY, 10'd1023, 4'd0,  1'b1, 4'd15});
    dir_rows.push_back('{OP_TOUCH, 10'd1023, 4'd15, 1'b0, 4'd0});
    dir_rows.push_back('{OP_TOUCH, 10'd1023, 4'd0,  1'b0, 4'd0});
    dir_rows.push_back('{OP_QUERY, 10'd1023, 4'd15, 1'b1, 4'd14});
    dir_rows.push_back('{OP_TOUCH, 10'd682,  4'd10, 1'b0, 4'd0});
    dir_rows.push_back('{OP_TOUCH, 10'd341,  4'd5,  1'b0, 4'd0});
    dir_rows.push_back('{OP_QUERY, 10'd682,  4'd5,  1'b0, 4'd0});
    dir_rows.push_back('{OP_QUERY, 10'd341,  4'd10, 1'b0, 4'd0});
    dir_rows.push_back('{OP_TOUCH, 10'd7,    4'd15, 1'b0, 4'd0});
    dir_rows.push_back('{OP_TOUCH, 10'd7,    4'd7,  1'b0, 4'd0});
    dir_rows.push_back('{OP_TOUCH, 10'd7,    4'd8,  1'b0, 4'd0});
    dir_rows.push_back('{OP_TOUCH, 10'd7,    4'd15, 1'b0, 4'd0});
    dir_rows.push_back('{OP_QUERY, 10'd7,    4'd0,  1'b0, 4'd0});

    hot_sets[0] = '0;
    hot_sets[1] = '1;
    for (int i = 2; i < 6; i++) hot_sets[i] = SET_W'($urandom_range(SETS - 1));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      offer(row.op, row.sidx, row.w, row.typed, row.victim);
    end

    // hot sets mostly, so touches pile up into deep stack orders;
    // some touches refill the current victim as after a miss
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(99) < 75) s = hot_sets[$urandom_range(5)];
      else s = SET_W'($urandom_range(SETS - 1));
      w = WAY_W'($urandom_range(WAYS - 1));
      if ($urandom_range(99) < 40) begin
        op = OP_QUERY;
      end else begin
        op = OP_TOUCH;
        if ($urandom_range(99) < 30) w = lru_victim(s);
      end
      offer(op, s, w, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_victims.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d items (%0d touches), %0d victim lookups compared, %0d mismatches",
             n_sent, n_touches, n_checked, errors);
    if (errors == 0) begin
      $display("true_lru_replacement regression: pass");
    end else begin
      $display("true_lru_replacement regression: fail");
    end
    $finish;
  end

endmodule
